/* src/status_light_pattern_player_defines.svh */
// Assertion macros for the status light pattern player.
// Used by the datapath; expects clk and rst_n in scope.
`ifndef STATUS_LIGHT_PATTERN_PLAYER_DEFINES_SVH
`define STATUS_LIGHT_PATTERN_PLAYER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SLPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/slpp_pkg.sv */
// Shared types, constants and the mood pattern table.
// No dependencies.
`default_nettype none

package slpp_pkg;

  localparam int DIM_FRAC_BITS   = 16;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int DIM_W           = DIM_FRAC_BITS + 1;
  localparam int SCALE_W         = SCALE_FRAC_BITS + 1;
  localparam int P1_W            = SCALE_W + DIM_W;
  localparam int P2_W            = P1_W + 8;
  localparam int SH              = SCALE_FRAC_BITS + DIM_FRAC_BITS;
  localparam int Q_W             = P2_W - SH;
  localparam int PER_W           = 12;

  localparam logic [3:0]         MOOD_NONE   = 4'd11;
  localparam logic [2:0]         MEMBER_DARK = 3'd7;
  localparam logic [SCALE_W-1:0] SCALE_ONE   = SCALE_W'(65536);
  localparam logic [DIM_W-1:0]   DIM_ONE     = DIM_W'(1) << DIM_FRAC_BITS;

  typedef enum logic [2:0] {PAT_OFF, PAT_STEADY, PAT_BLINK, PAT_ALT, PAT_SWEEP} kind_t;

  typedef enum logic [2:0] {
    OP_ENTER  = 3'd0,
    OP_FORGET = 3'd1,
    OP_STEP   = 3'd2,
    OP_SENT   = 3'd3,
    OP_FAILED = 3'd4
  } op_t;

  typedef enum logic [1:0] {LAMP_FRONT, LAMP_BACK, LAMP_HOLO, LAMP_LOGIC} lamp_t;

  typedef logic [2:0][7:0] color_t;   // [0] red, [1] green, [2] blue
  typedef color_t [5:0]    members_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         n;
    logic [PER_W-1:0]   period;
    logic [PER_W-1:0]   phase;
    logic [SCALE_W-1:0] scale;
    members_t           v;
  } pat_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       apply;
    logic       prep;
    logic       mod_init;
    logic       mod_step;
    logic       pick;
    logic       mul1;
    logic       mul2;
    logic       rnd;
    logic       emit;
    lamp_t      lamp;
    logic [4:0] bit_idx;
    logic [2:0] chan;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_step;
    logic skip;
    logic need_mod;
    logic suppress;
    logic out_free;
  } stat_t;

  localparam color_t C_NEU = {8'd255, 8'd0,   8'd0};
  localparam color_t C_ENG = {8'd255, 8'd255, 8'd0};
  localparam color_t C_SUC = {8'd0,   8'd255, 8'd0};
  localparam color_t C_PEN = {8'd0,   8'd255, 8'd255};
  localparam color_t C_DAN = {8'd0,   8'd0,   8'd255};

  function automatic color_t mono(input logic [7:0] x);
    return {8'd0, 8'd0, x};
  endfunction

  function automatic members_t one(input color_t c);
    return {120'd0, c};
  endfunction

  function automatic pat_t mk(input kind_t k, input logic [2:0] n,
                              input logic [PER_W-1:0] per, input logic [PER_W-1:0] ph,
                              input logic [SCALE_W-1:0] sc, input members_t v);
    pat_t p;
    p.kind   = k;
    p.n      = n;
    p.period = per;
    p.phase  = ph;
    p.scale  = sc;
    p.v      = v;
    return p;
  endfunction

  function automatic members_t breath();
    return {mono(8'd64), mono(8'd160), mono(8'd255), mono(8'd160), mono(8'd64),
            mono(8'd16)};
  endfunction

  function automatic pat_t mood_pat(input logic [3:0] mood, input lamp_t lamp);
    pat_t f, b, h, l, absent;
    absent = mk(PAT_OFF, 3'd0, '0, '0, SCALE_ONE, '0);
    f = absent;
    b = absent;
    h = absent;
    l = absent;
    case (mood)
      4'd0: begin
        f = mk(PAT_STEADY, 3'd1, '0, '0, SCALE_ONE, one(C_NEU));
        b = f;
      end
      4'd1: begin
        f = mk(PAT_SWEEP, 3'd3, 12'd450, '0, SCALE_ONE, {72'd0, C_SUC, C_ENG, C_NEU});
        b = mk(PAT_STEADY, 3'd1, '0, '0, SCALE_ONE, one(C_NEU));
        h = mk(PAT_SWEEP, 3'd3, 12'd450, '0, SCALE_ONE,
               {72'd0, mono(8'd255), mono(8'd96), mono(8'd16)});
        l = mk(PAT_STEADY, 3'd1, '0, '0, SCALE_ONE, one(mono(8'd255)));
      end
      4'd2: begin
        f = mk(PAT_STEADY, 3'd1, '0, '0, SCALE_ONE, one(C_ENG));
        b = f;
        h = mk(PAT_SWEEP, 3'd6, 12'd2200, '0, SCALE_ONE, breath());
        l = mk(PAT_BLINK, 3'd1, 12'd900, '0, SCALE_ONE, one(mono(8'd255)));
      end
      4'd3: begin
        f = mk(PAT_ALT, 3'd2, 12'd900, '0, SCALE_ONE, {96'd0, C_NEU, C_ENG});
        b = mk(PAT_ALT, 3'd2, 12'd900, 12'd450, SCALE_ONE, {96'd0, C_NEU, C_ENG});
        h = mk(PAT_SWEEP, 3'd6, 12'd1200, '0, SCALE_ONE, breath());
        l = mk(PAT_BLINK, 3'd1, 12'd450, '0, SCALE_ONE, one(mono(8'd255)));
      end
      4'd4: begin
        f = mk(PAT_STEADY, 3'd1, '0, '0, SCALE_ONE, one(C_ENG));
        b = f;
        h = mk(PAT_STEADY, 3'd1, '0, '0, SCALE_ONE, one(mono(8'd255)));
        l = h;
      end
      4'd5: begin
        f = mk(PAT_BLINK, 3'd1, 12'd2400, '0, SCALE_ONE, one(C_PEN));
        b = f;
      end
      4'd6: begin
        f = mk(PAT_BLINK, 3'd1, 12'd250, '0, SCALE_ONE, one(C_DAN));
        b = f;
      end
      4'd7: begin
        f = mk(PAT_BLINK, 3'd1, 12'd1200, '0, SCALE_ONE, one(C_PEN));
        b = f;
      end
      4'd8: begin
        f = mk(PAT_BLINK, 3'd1, 12'd1000, '0, SCALE_ONE, one(C_DAN));
        b = f;
      end
      4'd9: begin
        f = mk(PAT_BLINK, 3'd1, 12'd3000, '0, SCALE_ONE, one(C_NEU));
        b = mk(PAT_STEADY, 3'd1, '0, '0, SCALE_W'(16384), one(C_NEU));
      end
      4'd10: begin
        f = mk(PAT_STEADY, 3'd1, '0, '0, SCALE_W'(13107), one(C_NEU));
        b = f;
      end
      default: begin
        f = absent;
      end
    endcase
    unique case (lamp)
      LAMP_FRONT: return f;
      LAMP_BACK:  return b;
      LAMP_HOLO:  return h;
      LAMP_LOGIC: return l;
      default:    return absent;
    endcase
  endfunction

  function automatic logic dimmable(input logic [3:0] mood);
    return (mood != 4'd6) && (mood != 4'd8);
  endfunction

  // frame slots: 0..2 front RGB, 3 logic, 4..6 back RGB, 7 holo
  function automatic lamp_t chan_lamp(input logic [2:0] chan);
    unique case (chan)
      3'd0, 3'd1, 3'd2: return LAMP_FRONT;
      3'd3:             return LAMP_LOGIC;
      3'd4, 3'd5, 3'd6: return LAMP_BACK;
      default:          return LAMP_HOLO;
    endcase
  endfunction

  function automatic logic [1:0] chan_comp(input logic [2:0] chan);
    return (chan == 3'd3 || chan == 3'd7) ? 2'd0 : chan[1:0];
  endfunction

endpackage

`default_nettype wire

/* src/slpp_ctrl.sv */
// Sequencer for the status light pattern player.
// Depends on slpp_pkg; drives cmd_t into slpp_dp and reads stat_t back.
`default_nettype none

module slpp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire slpp_pkg::stat_t stat,
  output slpp_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_LAMP, ST_MOD, ST_PICK,
    ST_MUL1, ST_MUL2, ST_RND, ST_CMP, ST_EMIT
  } state_t;

  state_t              state_r;
  slpp_pkg::lamp_t     lamp_r;
  logic [4:0]          bit_r;
  logic [2:0]          chan_r;

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lamp_r  <= slpp_pkg::LAMP_FRONT;
      bit_r   <= '0;
      chan_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) state_r <= ST_DECODE;
        end
        ST_DECODE: begin
          lamp_r <= slpp_pkg::LAMP_FRONT;
          if (!stat.is_step || stat.skip) state_r <= ST_IDLE;
          else                            state_r <= ST_LAMP;
        end
        ST_LAMP: begin
          bit_r <= 5'd31;
          state_r <= stat.need_mod ? ST_MOD : ST_PICK;
        end
        ST_MOD: begin
          bit_r <= bit_r - 5'd1;
          if (bit_r == 5'd0) state_r <= ST_PICK;
        end
        ST_PICK: begin
          chan_r <= '0;
          if (lamp_r == slpp_pkg::LAMP_LOGIC) begin
            state_r <= ST_MUL1;
          end else begin
            lamp_r  <= slpp_pkg::lamp_t'(lamp_r + 2'd1);
            state_r <= ST_LAMP;
          end
        end
        ST_MUL1: state_r <= ST_MUL2;
        ST_MUL2: state_r <= ST_RND;
        ST_RND: begin
          chan_r  <= chan_r + 3'd1;
          state_r <= (chan_r == 3'd7) ? ST_CMP : ST_MUL1;
        end
        ST_CMP: begin
          state_r <= stat.suppress ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (stat.out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.lamp     = lamp_r;
    cmd.bit_idx  = bit_r;
    cmd.chan     = chan_r;
    cmd.load     = (state_r == ST_IDLE) && in_tvalid;
    cmd.apply    = (state_r == ST_DECODE);
    cmd.prep     = (state_r == ST_DECODE);
    cmd.mod_init = (state_r == ST_LAMP);
    cmd.mod_step = (state_r == ST_MOD);
    cmd.pick     = (state_r == ST_PICK);
    cmd.mul1     = (state_r == ST_MUL1);
    cmd.mul2     = (state_r == ST_MUL2);
    cmd.rnd      = (state_r == ST_RND);
    cmd.emit     = (state_r == ST_EMIT) && stat.out_free;
  end

endmodule

`default_nettype wire

/* src/slpp_dp.sv */
// Datapath: mood state, serial modulo, level multiplier, output register.
// Depends on slpp_pkg and status_light_pattern_player_defines.svh.
`default_nettype none
`include "status_light_pattern_player_defines.svh"

module slpp_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [15:0]     cfg_wdata,
  input  wire logic [55:0]     in_tdata,
  input  wire logic [2:0]      in_tuser,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [63:0]          out_tdata,
  input  wire slpp_pkg::cmd_t  cmd,
  output slpp_pkg::stat_t      stat
);

  logic [15:0]                     gap_r;
  logic [2:0]                      op_r;
  logic [3:0]                      mood_r;
  logic [31:0]                     now_r;
  logic [slpp_pkg::DIM_W-1:0]      dim_r;
  logic [3:0]                      cur_mood_r;
  logic [31:0]                     entered_r;
  logic [31:0]                     last_wr_r;
  logic                            has_wr_r;
  logic                            owed_r;
  logic [7:0][7:0]                 committed_r;
  logic [7:0][7:0]                 proposed_r;
  logic [7:0][7:0]                 frame_r;
  logic [31:0]                     elapsed_r;
  logic [slpp_pkg::PER_W-1:0]      rem_r;
  logic [3:0][2:0]                 pick_r;
  logic [slpp_pkg::P1_W-1:0]       p1_r;
  logic [slpp_pkg::P2_W-1:0]       p2_r;
  logic                            out_tvalid_r;
  logic [63:0]                     out_tdata_r;

  slpp_pkg::pat_t                  pat_l;
  slpp_pkg::pat_t                  pat_c;
  logic [3:0]                      mood_in;
  logic [slpp_pkg::PER_W:0]        mod_sh;
  logic [slpp_pkg::PER_W:0]        mod_nxt;
  logic [slpp_pkg::PER_W:0]        r2;
  logic [2:0]                      sweep_idx;
  logic [2:0]                      member_nxt;
  logic [2:0]                      member_c;
  logic [7:0]                      v_c;
  logic [slpp_pkg::DIM_W-1:0]      quiet;
  logic [slpp_pkg::Q_W-1:0]        q;
  logic [slpp_pkg::SH-1:0]         frac;
  logic                            inc;
  logic [slpp_pkg::Q_W:0]          q_rnd;
  logic [7:0]                      level;

  assign mood_in = (in_tdata[3:0] > slpp_pkg::MOOD_NONE) ? slpp_pkg::MOOD_NONE
                                                         : in_tdata[3:0];
  assign pat_l   = slpp_pkg::mood_pat(cur_mood_r, cmd.lamp);
  assign pat_c   = slpp_pkg::mood_pat(cur_mood_r, slpp_pkg::chan_lamp(cmd.chan));
  assign quiet   = slpp_pkg::dimmable(cur_mood_r) ? dim_r : slpp_pkg::DIM_ONE;

  // one restoring step of elapsed mod period
  always_comb begin
    mod_sh  = {rem_r, elapsed_r[cmd.bit_idx]};
    mod_nxt = (mod_sh >= {1'b0, pat_l.period}) ? mod_sh - {1'b0, pat_l.period} : mod_sh;
  end

  always_comb begin
    sweep_idx = '0;
    for (int k = 1; k < 6; k++) begin
      if (3'(k) < pat_l.n && elapsed_r >= {20'd0, pat_l.period} * 32'(k))
        sweep_idx = sweep_idx + 3'd1;
    end
    r2 = {1'b0, rem_r} + {1'b0, pat_l.phase};
    if (r2 >= {1'b0, pat_l.period}) r2 = r2 - {1'b0, pat_l.period};
    unique case (pat_l.kind)
      slpp_pkg::PAT_STEADY: member_nxt = 3'd0;
      slpp_pkg::PAT_SWEEP:  member_nxt = sweep_idx;
      slpp_pkg::PAT_BLINK:  member_nxt = ({r2, 1'b0} < {2'b0, pat_l.period}) ? 3'd0
                                                       : slpp_pkg::MEMBER_DARK;
      slpp_pkg::PAT_ALT:    member_nxt = ({r2, 1'b0} < {2'b0, pat_l.period}) ? 3'd0 : 3'd1;
      default:              member_nxt = slpp_pkg::MEMBER_DARK;
    endcase
  end

  always_comb begin
    member_c = pick_r[slpp_pkg::chan_lamp(cmd.chan)];
    v_c      = (member_c == slpp_pkg::MEMBER_DARK) ? 8'd0
             : pat_c.v[member_c][slpp_pkg::chan_comp(cmd.chan)];
  end

  // round half to even, saturate at 255
  always_comb begin
    q     = p2_r[slpp_pkg::P2_W-1:slpp_pkg::SH];
    frac  = p2_r[slpp_pkg::SH-1:0];
    inc   = (frac > {1'b1, {(slpp_pkg::SH-1){1'b0}}}) ||
            ((frac == {1'b1, {(slpp_pkg::SH-1){1'b0}}}) && q[0]);
    q_rnd = {1'b0, q} + {{slpp_pkg::Q_W{1'b0}}, inc};
    level = (q_rnd > (slpp_pkg::Q_W+1)'(255)) ? 8'd255 : q_rnd[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r        <= 16'd20;
      cur_mood_r   <= slpp_pkg::MOOD_NONE;
      entered_r    <= '0;
      last_wr_r    <= '0;
      has_wr_r     <= 1'b0;
      owed_r       <= 1'b0;
      committed_r  <= '0;
      proposed_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) gap_r <= cfg_wdata;
      if (cmd.apply) begin
        case (op_r)
          slpp_pkg::OP_ENTER: begin
            if (mood_r != cur_mood_r) begin
              cur_mood_r <= mood_r;
              entered_r  <= now_r;
              owed_r     <= (mood_r != slpp_pkg::MOOD_NONE);
            end
          end
          slpp_pkg::OP_FORGET: owed_r <= (cur_mood_r != slpp_pkg::MOOD_NONE);
          slpp_pkg::OP_SENT: begin
            committed_r <= proposed_r;
            last_wr_r   <= now_r;
            has_wr_r    <= 1'b1;
            owed_r      <= 1'b0;
          end
          slpp_pkg::OP_FAILED: begin
            last_wr_r <= now_r;
            has_wr_r  <= 1'b1;
            owed_r    <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.emit) begin
        proposed_r   <= frame_r;
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_tuser;
      mood_r <= mood_in;
      now_r  <= in_tdata[35:4];
      dim_r  <= in_tdata[52:36];
    end
    if (cmd.prep)     elapsed_r <= now_r - entered_r;
    if (cmd.mod_init) rem_r <= '0;
    if (cmd.mod_step) rem_r <= mod_nxt[slpp_pkg::PER_W-1:0];
    if (cmd.pick)     pick_r[cmd.lamp] <= member_nxt;
    if (cmd.mul1)     p1_r <= pat_c.scale * quiet;
    if (cmd.mul2)     p2_r <= p1_r * v_c;
    if (cmd.rnd)      frame_r[cmd.chan] <= level;
    if (cmd.emit)     out_tdata_r <= frame_r;
  end

  always_comb begin
    stat.is_step  = (op_r == slpp_pkg::OP_STEP);
    stat.skip     = (cur_mood_r == slpp_pkg::MOOD_NONE) ||
                    (has_wr_r && ((now_r - last_wr_r) < {16'd0, gap_r}));
    stat.need_mod = (pat_l.kind == slpp_pkg::PAT_BLINK) ||
                    (pat_l.kind == slpp_pkg::PAT_ALT);
    stat.suppress = !owed_r && (frame_r == committed_r);
    stat.out_free = !out_tvalid_r || out_tready;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `SLPP_ASSERT_NOW(a_emit_free, cmd.emit, !out_tvalid_r || out_tready, "emit into full output")
  `SLPP_ASSERT_NEXT(a_emit_valid, cmd.emit, out_tvalid_r && out_tdata_r == proposed_r, "emit lost")
  `SLPP_ASSERT_NOW(a_rem_bound, cmd.mod_step, rem_r < pat_l.period, "remainder out of range")

endmodule

`default_nettype wire

/* src/status_light_pattern_player.sv */
// Top level of the status light pattern player.
// Depends on slpp_pkg, slpp_ctrl and slpp_dp.
//
// channel | dir | handshake            | payload
// cfg     | in  | cfg_we               | cfg_wdata: min_write_gap_ms
// in      | in  | in_tvalid/in_tready  | in_tuser: operation; in_tdata: mood, now_ms, dim
// out     | out | out_tvalid/out_tready| out_tdata: eight 8-bit light levels
//
// A non-step transaction is only loaded and decoded; a step also takes four lamp
// passes (lamp, pick), plus a serial modulo of elapsed time for each blinking or
// alternating lamp, plus eight channels through the level multiplier (multiply,
// multiply, round), then compare and emit; an unchanged frame skips the emit.
// Reset (rst_n low, synchronous) returns to no mood, gap 20 ms, zero frames.
// A finished frame sits in the output register; the next transaction is
// accepted meanwhile, and only a second frame waits for out_tready.
`default_nettype none

module status_light_pattern_player (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // min_write_gap_ms
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,    // mood[3:0], now_ms[35:4], dim[52:36], zero fill
  input  wire logic [2:0]  in_tuser,    // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata    // front_red, front_green, front_blue, logic_level,
                                        // back_red, back_green, back_blue, holo_level
);

  slpp_pkg::cmd_t  cmd;
  slpp_pkg::stat_t stat;

  // sequencer: walks lamps, modulo bits and channels
  slpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // state, pattern table lookup, arithmetic and output register
  slpp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for status_light_pattern_player.
// Depends on slpp_pkg (op and pattern-kind enums) and the RTL top level.
`timescale 1ns / 100ps

module tb_top;
  import slpp_pkg::*;

  // One input transaction, kept at raw widths so bad codes can be driven too.
  typedef struct {
    logic [2:0]  op;
    logic [3:0]  mood;
    logic [31:0] now;
    logic [16:0] dim;
  } light_cmd_t;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 200;  // longer than the worst step takes

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // mood[3:0], now_ms[35:4], dim[52:36], zero fill
  logic [2:0]  in_tuser = '0;   // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // front r,g,b, logic, back r,g,b, holo (low byte first)

  always #5 clk = ~clk;

  status_light_pattern_player dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  light_cmd_t  pending_cmds[$];
  logic [63:0] frames_due[$];
  int          idle_mode = 0;    // 0 none, 1 sender, 2 receiver, 3 both
  int          hold_requests = 0;
  int          errors = 0;
  int          cmds_sent = 0;
  int          frames_seen = 0;
  bit          cmd_taken = 1'b0;

  // Shadow of the block's state
  logic [15:0] gap_ms;
  logic [3:0]  cur_mood;
  logic [31:0] mood_start, last_wr_time;
  bit          has_written, write_owed;
  logic [63:0] committed, proposed;

  // ---------------------------------------------------------------------------
  // Mood table: kind, member count, period, phase, Q1.16 scale per lamp.
  // lamp: 0 front, 1 back, 2 holo, 3 logic
  // ---------------------------------------------------------------------------
  function automatic void lamp_shape(input logic [3:0] mood, input int lamp,
                                     output kind_t k, output int n, output int per,
                                     output int ph, output int sc);
    k = PAT_OFF; n = 1; per = 0; ph = 0; sc = 65536;
    case (mood)
      4'd0: if (lamp < 2) k = PAT_STEADY;
      4'd1: begin
        k = (lamp == 1 || lamp == 3) ? PAT_STEADY : PAT_SWEEP;
        if (k == PAT_SWEEP) begin n = 3; per = 450; end
      end
      4'd2: case (lamp)
        0, 1: k = PAT_STEADY;
        2: begin k = PAT_SWEEP; n = 6; per = 2200; end
        default: begin k = PAT_BLINK; per = 900; end
      endcase
      4'd3: case (lamp)
        0: begin k = PAT_ALT; n = 2; per = 900; end
        1: begin k = PAT_ALT; n = 2; per = 900; ph = 450; end
        2: begin k = PAT_SWEEP; n = 6; per = 1200; end
        default: begin k = PAT_BLINK; per = 450; end
      endcase
      4'd4: k = PAT_STEADY;
      4'd5: if (lamp < 2) begin k = PAT_BLINK; per = 2400; end
      4'd6: if (lamp < 2) begin k = PAT_BLINK; per = 250; end
      4'd7: if (lamp < 2) begin k = PAT_BLINK; per = 1200; end
      4'd8: if (lamp < 2) begin k = PAT_BLINK; per = 1000; end
      4'd9: if (lamp == 0) begin
        k = PAT_BLINK; per = 3000;
      end else if (lamp == 1) begin
        k = PAT_STEADY; sc = 16384;
      end
      4'd10: if (lamp < 2) begin k = PAT_STEADY; sc = 13107; end
      default: k = PAT_OFF;
    endcase
  endfunction

  // Raw level of member m, component c (0 r, 1 g, 2 b; mono lamps use 0).
  function automatic logic [7:0] lamp_value(input logic [3:0] mood, input int lamp,
                                            input int m, input int c);
    logic [7:0] neu[3], eng[3], suc[3], pen[3], dan[3], breath_lv[6], rise[3];
    neu = '{0, 0, 255}; eng = '{0, 255, 255}; suc = '{0, 255, 0};
    pen = '{255, 255, 0}; dan = '{255, 0, 0};
    breath_lv = '{16, 64, 160, 255, 160, 64};
    rise = '{16, 96, 255};
    if (lamp >= 2) begin
      if (mood == 4'd1 && lamp == 2) return rise[m];
      if ((mood == 4'd2 || mood == 4'd3) && lamp == 2) return breath_lv[m];
      return 8'd255;
    end
    case (mood)
      4'd1: return (lamp == 1) ? neu[c] : (m == 0 ? neu[c] : (m == 1 ? eng[c] : suc[c]));
      4'd2, 4'd4: return eng[c];
      4'd3: return (m == 0) ? eng[c] : neu[c];
      4'd5, 4'd7: return pen[c];
      4'd6, 4'd8: return dan[c];
      default: return neu[c];
    endcase
  endfunction

  // Member lit at elapsed time t, or -1 when dark/absent.
  function automatic int lit_member(input kind_t k, input int n, input int per,
                                    input int ph, input logic [31:0] t);
    logic [31:0] r, idx;
    case (k)
      PAT_STEADY: return 0;
      PAT_SWEEP: begin
        idx = t / per;
        return (idx >= n - 1) ? n - 1 : int'(idx);
      end
      PAT_BLINK, PAT_ALT: begin
        r = ((t % per) + ph) % per;
        if (r * 2 < per) return 0;
        return (k == PAT_BLINK) ? -1 : 1;
      end
      default: return -1;
    endcase
  endfunction

  // v * scale * dim >> 32, round half to even, saturate.
  function automatic logic [7:0] scaled_level(input logic [7:0] v, input int sc,
                                              input logic [16:0] dim);
    longint unsigned x, q, rem;
    x = longint'(v) * longint'(sc) * longint'(dim);
    q = x >> 32;
    rem = x & 64'hFFFF_FFFF;
    if (rem > 64'h8000_0000 || (rem == 64'h8000_0000 && q[0])) q++;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [63:0] light_frame(input logic [3:0] mood, input logic [31:0] t,
                                              input logic [16:0] dim);
    logic [63:0] f;
    logic [16:0] d;
    kind_t       k;
    int          n, per, ph, sc, m, slot;
    f = '0;
    d = (mood == 4'd6 || mood == 4'd8) ? 17'h10000 : dim;
    for (int lamp = 0; lamp < 4; lamp++) begin
      lamp_shape(mood, lamp, k, n, per, ph, sc);
      m = lit_member(k, n, per, ph, t);
      if (m >= 0) begin
        if (lamp < 2) begin
          for (int c = 0; c < 3; c++)
            f[(lamp*4 + c)*8 +: 8] = scaled_level(lamp_value(mood, lamp, m, c), sc, d);
        end else begin
          slot = (lamp == 2) ? 7 : 3;
          f[slot*8 +: 8] = scaled_level(lamp_value(mood, lamp, m, 0), sc, d);
        end
      end
    end
    return f;
  endfunction

  // Apply one accepted transaction to the shadow state.
  task automatic track_cmd(input light_cmd_t c);
    logic [3:0]  md;
    logic [63:0] f;
    md = (c.mood > MOOD_NONE) ? MOOD_NONE : c.mood;
    case (c.op)
      OP_ENTER: if (md != cur_mood) begin
        cur_mood = md;
        mood_start = c.now;
        write_owed = (md != MOOD_NONE);
      end
      OP_FORGET: write_owed = (cur_mood != MOOD_NONE);
      OP_STEP: if (cur_mood != MOOD_NONE &&
                   !(has_written && (c.now - last_wr_time) < {16'd0, gap_ms})) begin
        f = light_frame(cur_mood, c.now - mood_start, c.dim);
        if (write_owed || f != committed) begin
          proposed = f;
          frames_due.push_back(f);
        end
      end
      OP_SENT: begin
        committed = proposed;
        last_wr_time = c.now;
        has_written = 1;
        write_owed = 0;
      end
      OP_FAILED: begin
        last_wr_time = c.now;
        has_written = 1;
        write_owed = 1;
      end
      default: ;  // unused codes are ignored
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Rising edge: shadow state, register writes and accepted input transactions
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    light_cmd_t c;
    if (!rst_n) begin
      gap_ms = 16'd20; cur_mood = MOOD_NONE; mood_start = '0; last_wr_time = '0;
      has_written = 0; write_owed = 0; committed = '0; proposed = '0;
    end else begin
      if (cfg_we) gap_ms = cfg_wdata;
      if (in_tvalid && in_tready) begin
        c.op = in_tuser; c.mood = in_tdata[3:0];
        c.now = in_tdata[35:4]; c.dim = in_tdata[52:36];
        track_cmd(c);
        cmd_taken = 1'b1;
        cmds_sent++;
      end
    end
  end

  // Driver: holds a transaction until taken, then maybe idles.
  always @(negedge clk) begin
    light_cmd_t c;
    bit         idle;
    idle = (idle_mode == 1) ? ($urandom_range(99) < 71) :
           (idle_mode == 3) ? ($urandom_range(99) < 6) : 1'b0;
    if (rst_n && !(in_tvalid && !cmd_taken)) begin
      if (pending_cmds.size() > 0 && !idle) begin
        c = pending_cmds.pop_front();
        in_tuser <= c.op;
        in_tdata <= {3'b000, c.dim, c.now, c.mood};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    cmd_taken = 1'b0;
  end

  // Receiver: random stalls plus an occasional long hold-off.
  always @(negedge clk) begin
    int hold_cnt, holds_done;
    if (holds_done != hold_requests) begin
      holds_done = hold_requests;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (idle_mode == 2) begin
      out_tready <= ($urandom_range(99) >= 71);
    end else if (idle_mode == 3) begin
      out_tready <= ($urandom_range(99) >= 6);
    end else begin
      out_tready <= rst_n;
    end
  end

  // Monitor: compare each frame with the oldest one due.
  always @(posedge clk) begin
    logic [63:0] want;
    string       field_names[8];
    field_names = '{"front_red", "front_green", "front_blue", "logic_level",
                    "back_red", "back_green", "back_blue", "holo_level"};
    if (rst_n && out_tvalid && out_tready) begin
      frames_seen++;
      if (frames_due.size() == 0) begin
        $error("frame with none due: %h", out_tdata);
        errors++;
      end else begin
        want = frames_due.pop_front();
        for (int i = 0; i < 8; i++)
          if (want[i*8 +: 8] !== out_tdata[i*8 +: 8]) begin
            $error("%s: expected %0d, got %0d", field_names[i], want[i*8 +: 8],
                   out_tdata[i*8 +: 8]);
            errors++;
          end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [31:0] clock_ms;

  task automatic add_cmd(input logic [2:0] op, input logic [3:0] mood,
                         input logic [31:0] now, input logic [16:0] dim);
    light_cmd_t c;
    c.op = op; c.mood = mood; c.now = now; c.dim = dim;
    pending_cmds.push_back(c);
  endtask

  // Random mix, mostly steps, with mood entries, sent/failed acks and some noise.
  task automatic add_random(input int count);
    int          pick;
    logic [16:0] dim;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) clock_ms += $urandom;
      else clock_ms += $urandom_range(($urandom_range(3) == 0) ? 3000 : 120);
      case ($urandom_range(3))
        0: dim = 17'($urandom_range(131071));
        1: dim = 17'h10000;
        default: dim = 17'($urandom_range(65536));
      endcase
      if (pick < 14) add_cmd(OP_ENTER, ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                               : 4'($urandom_range(10)),
                             clock_ms, dim);
      else if (pick < 20) add_cmd(OP_FORGET, 4'($urandom), clock_ms, dim);
      else if (pick < 68) add_cmd(OP_STEP, 4'($urandom), clock_ms, dim);
      else if (pick < 86) add_cmd(OP_SENT, 4'($urandom), clock_ms, dim);
      else if (pick < 95) add_cmd(OP_FAILED, 4'($urandom), clock_ms, dim);
      else add_cmd(3'($urandom_range(7, 5)), 4'($urandom), clock_ms, dim);
    end
  endtask

  // Block is idle: nothing queued, nothing due, pipeline drained.
  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_tvalid || frames_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap(input logic [15:0] g);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] gaps[6];
    gaps = '{16'd20, 16'd0, 16'd65535, 16'd5, 16'd0, 16'd20};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: sent before any frame commits zeros, every mood, range extremes.
    add_cmd(OP_SENT, 4'd0, 32'd5, 17'h10000);
    add_cmd(OP_STEP, 4'd0, 32'd40, 17'h10000);          // no mood: silent
    for (int m = 0; m <= 10; m++) begin
      add_cmd(OP_ENTER, 4'(m), 32'd100 + 32'(m*1000), 17'h10000);
      add_cmd(OP_STEP, 4'd0, 32'd100 + 32'(m*1000) + 32'd600,
              (m % 2) ? 17'h1FFFF : 17'h0);
    end
    add_cmd(OP_SENT, 4'd0, 32'd20000, 17'h10000);
    add_cmd(OP_FORGET, 4'd0, 32'd20001, 17'h10000);
    add_cmd(OP_STEP, 4'd0, 32'd20100, 17'h08000);
    add_cmd(OP_FAILED, 4'd0, 32'd20200, 17'h10000);
    add_cmd(OP_ENTER, 4'd15, 32'hFFFF_FFF0, 17'h10000);  // out-of-range mood is none
    add_cmd(OP_ENTER, 4'd3, 32'hFFFF_FFF0, 17'h1FFFF);
    add_cmd(OP_STEP, 4'd0, 32'h0000_0100, 17'h1FFFF);    // elapsed time wraps
    add_cmd(3'd7, 4'd3, 32'hFFFF_FFFF, 17'h1FFFF);
    clock_ms = $urandom;

    // Random phases: register setting and idling pattern change between them.
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_gap((ph == 3) ? 16'($urandom_range(200)) : gaps[ph]);
      idle_mode = ph % 4;
      if (ph == 4) hold_requests++;
      add_random(310);
    end
    wait_drained();

    $display("covered %0d input transactions and %0d frames over six gap settings",
             cmds_sent, frames_seen);
    if (errors == 0 && frames_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
